// ----- rtl/sbbf_pkg.sv -----
// Shared types and constants for the split-block Bloom filter engine.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none

package sbbf_pkg;

  localparam int DEFAULT_MAX_BLOCKS = 1024;
  localparam int WORDS_PER_BLOCK    = 8;
  localparam int WORD_W             = 32;
  localparam int BLOCK_W            = WORDS_PER_BLOCK * WORD_W;
  localparam int CFG_W              = 11;
  localparam int ROW_W              = 16;
  localparam int QUEUE_DEPTH        = 2;

  // Action codes carried by an input item.
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_PROBE  = 3'd1;
  localparam logic [2:0] ACT_CLEAR  = 3'd2;
  localparam logic [2:0] ACT_LOAD   = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  // Salts that pick one bit in each word of a block; entry 0 is the first word.
  localparam logic [WORDS_PER_BLOCK-1:0][WORD_W-1:0] SALTS = {
    32'h5c6bfb31, 32'h9efc4947, 32'h2df1424b, 32'h705495c7,
    32'ha2b7289d, 32'h8824ad5b, 32'h44974d91, 32'h47b6137b
  };

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] hash;
    logic [12:0] word_address;
    logic [31:0] word_data;
  } item_t;

  typedef struct packed {
    logic        may_contain;
    logic [31:0] read_data;
  } result_t;

  // Work kinds after classification; out-of-range and unused actions are K_NOP.
  typedef enum logic [2:0] {
    K_INSERT,
    K_PROBE,
    K_CLEAR,
    K_LOAD,
    K_READ,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t                           kind;
    logic [ROW_W-1:0]                row;
    logic [2:0]                      word_sel;
    logic [WORD_W-1:0]               word_data;
    logic [WORDS_PER_BLOCK-1:0][4:0] pos;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/sbbf_front.sv -----
// Front end: accepts items, holds the block count and turns each item into a
// queue entry (block row, bit positions). Depends on sbbf_pkg.
`default_nettype none

module sbbf_front #(
  parameter int MAX_BLOCKS = sbbf_pkg::DEFAULT_MAX_BLOCKS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire sbbf_pkg::item_t             item,
  input  wire logic                        cfg_wr_en,
  input  wire logic [sbbf_pkg::CFG_W-1:0]  cfg_wr_data,
  input  wire logic                        sweeping,
  input  wire logic                        q_full,
  output logic                             busy,
  output logic                             push,
  output sbbf_pkg::entry_t                 entry
);

  logic                           f_valid;
  sbbf_pkg::item_t                f_item;
  logic [sbbf_pkg::CFG_W-1:0]     eff;
  logic [sbbf_pkg::CFG_W-1:0]     eff_next;
  logic [32+sbbf_pkg::CFG_W-1:0]  blk_prod;
  logic [9:0]                     a_blk;
  logic                           a_ok;
  logic                           accept;

  assign busy   = f_valid | sweeping;
  assign accept = start & ~busy;
  assign push   = f_valid & ~q_full;

  // Block count of zero acts as one; anything above the store size saturates.
  always_comb begin
    eff_next = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      eff_next = sbbf_pkg::CFG_W'(1);
    end else if (32'(cfg_wr_data) > 32'(MAX_BLOCKS)) begin
      eff_next = sbbf_pkg::CFG_W'(MAX_BLOCKS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      eff     <= sbbf_pkg::CFG_W'(1);
    end else begin
      if (accept) begin
        f_valid <= 1'b1;
      end else if (push) begin
        f_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        eff <= eff_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= item;
    end
  end

  assign blk_prod = (32+sbbf_pkg::CFG_W)'(f_item.hash[63:32])
                  * (32+sbbf_pkg::CFG_W)'(eff);
  assign a_blk    = f_item.word_address[12:3];
  assign a_ok     = 32'(a_blk) < 32'(MAX_BLOCKS);

  always_comb begin
    logic [31:0] prod;
    entry.kind      = sbbf_pkg::K_NOP;
    entry.row       = sbbf_pkg::ROW_W'(blk_prod[32+sbbf_pkg::CFG_W-1:32]);
    entry.word_sel  = f_item.word_address[2:0];
    entry.word_data = f_item.word_data;
    for (int i = 0; i < sbbf_pkg::WORDS_PER_BLOCK; i++) begin
      prod         = f_item.hash[31:0] * sbbf_pkg::SALTS[i];
      entry.pos[i] = prod[31:27];
    end
    case (f_item.action)
      sbbf_pkg::ACT_INSERT: entry.kind = sbbf_pkg::K_INSERT;
      sbbf_pkg::ACT_PROBE:  entry.kind = sbbf_pkg::K_PROBE;
      sbbf_pkg::ACT_CLEAR:  entry.kind = sbbf_pkg::K_CLEAR;
      sbbf_pkg::ACT_LOAD: begin
        entry.row  = sbbf_pkg::ROW_W'(a_blk);
        entry.kind = a_ok ? sbbf_pkg::K_LOAD : sbbf_pkg::K_NOP;
      end
      sbbf_pkg::ACT_READ: begin
        entry.row  = sbbf_pkg::ROW_W'(a_blk);
        entry.kind = a_ok ? sbbf_pkg::K_READ : sbbf_pkg::K_NOP;
      end
      default: entry.kind = sbbf_pkg::K_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/sbbf_queue.sv -----
// Small register queue between the front end and the back end.
// Depends on sbbf_pkg for the entry type and depth.
`default_nettype none

module sbbf_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire sbbf_pkg::entry_t wdata,
  input  wire logic             pop,
  output sbbf_pkg::entry_t      rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int DEPTH = sbbf_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  sbbf_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sbbf_back.sv -----
// Back end: owns the block store, runs the read-modify-write of each entry,
// the clearing sweep, and drives the result. Depends on sbbf_pkg.
`default_nettype none

module sbbf_back #(
  parameter int MAX_BLOCKS = sbbf_pkg::DEFAULT_MAX_BLOCKS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire sbbf_pkg::entry_t head,
  output logic                  pop,
  output logic                  sweeping,
  output logic                  done,
  output sbbf_pkg::result_t     result
);

  localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                          state;
  logic [BW-1:0]                   sweep_cnt;
  logic                            from_action;
  sbbf_pkg::entry_t                cur;

  logic [sbbf_pkg::BLOCK_W-1:0]    mem [MAX_BLOCKS];
  logic [sbbf_pkg::BLOCK_W-1:0]    rdata;
  logic                            mem_re;
  logic                            mem_we;
  logic [BW-1:0]                   mem_waddr;
  logic [sbbf_pkg::BLOCK_W-1:0]    mem_wdata;
  logic [sbbf_pkg::BLOCK_W-1:0]    new_row;
  logic                            hit;
  logic [sbbf_pkg::WORD_W-1:0]     rd_word;

  assign pop      = (state == S_IDLE) && !q_empty;
  assign sweeping = (state == S_SWEEP);
  assign mem_re   = pop && (head.kind == sbbf_pkg::K_INSERT || head.kind == sbbf_pkg::K_PROBE
                         || head.kind == sbbf_pkg::K_LOAD || head.kind == sbbf_pkg::K_READ);

  // Update the fetched block word by word, test the probe bits and pick the read word.
  always_comb begin
    logic [sbbf_pkg::WORD_W-1:0] w;
    hit     = 1'b1;
    rd_word = '0;
    for (int i = 0; i < sbbf_pkg::WORDS_PER_BLOCK; i++) begin
      w = rdata[i*sbbf_pkg::WORD_W +: sbbf_pkg::WORD_W];
      if (!w[cur.pos[i]]) begin
        hit = 1'b0;
      end
      if (cur.word_sel == 3'(i)) begin
        rd_word = w;
      end
      if (cur.kind == sbbf_pkg::K_INSERT) begin
        w[cur.pos[i]] = 1'b1;
      end
      if (cur.kind == sbbf_pkg::K_LOAD && cur.word_sel == 3'(i)) begin
        w = cur.word_data;
      end
      new_row[i*sbbf_pkg::WORD_W +: sbbf_pkg::WORD_W] = w;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur.row[BW-1:0];
    mem_wdata = new_row;
    if (state == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_cnt;
      mem_wdata = '0;
    end else if (state == S_EXEC) begin
      mem_we = (cur.kind == sbbf_pkg::K_INSERT) || (cur.kind == sbbf_pkg::K_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[head.row[BW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_cnt   <= '0;
      from_action <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + BW'(1);
          if (sweep_cnt == BW'(MAX_BLOCKS - 1)) begin
            state              <= S_IDLE;
            done               <= from_action;
            result.may_contain <= 1'b0;
            result.read_data   <= '0;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cur <= head;
            if (head.kind == sbbf_pkg::K_CLEAR) begin
              state       <= S_SWEEP;
              sweep_cnt   <= '0;
              from_action <= 1'b1;
            end else if (mem_re) begin
              state <= S_EXEC;
            end else begin
              done               <= 1'b1;
              result.may_contain <= 1'b0;
              result.read_data   <= '0;
            end
          end
        end
        S_EXEC: begin
          state              <= S_IDLE;
          done               <= 1'b1;
          result.may_contain <= (cur.kind == sbbf_pkg::K_PROBE) && hit;
          result.read_data   <= (cur.kind == sbbf_pkg::K_READ) ? rd_word : '0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_result_field : assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.may_contain && (result.read_data != '0)))
    else $error("probe and read results both nonzero");

  a_exec_after_idle : assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> ($past(state) == S_IDLE))
    else $error("execute step not preceded by a fetch");

  a_quiet_sweep : assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> !done)
    else $error("result issued during a clearing sweep");

endmodule

`default_nettype wire

// ----- rtl/split_block_bloom_filter.sv -----
// Top level of the split-block Bloom filter engine: front end, queue, back end.
// Depends on sbbf_pkg, sbbf_front, sbbf_queue and sbbf_back.
//
//   Channel   Ports                     Handshake
//   ------    ----------------------    ------------------------------------------
//   input     item (item_t)             taken at a clock edge with start=1, busy=0
//   result    result (result_t)         valid for the one cycle that done is high
//   config    cfg_wr_en, cfg_wr_data    block_count written when cfg_wr_en is high
//
// Insert, probe, load word and read word pass the back-end states S_IDLE (block
// fetch from the synchronous store) and S_EXEC (write-back for insert and load,
// and the result); the front end takes a new item once it has pushed the last.
// Reset (synchronous, active high) and clear all sweep all MAX_BLOCKS blocks,
// one block per cycle with busy high; a clear answers at the end. The receiver
// cannot stall; busy stays high while a full two-entry queue stalls the front end.
`default_nettype none

module split_block_bloom_filter #(
  parameter int MAX_BLOCKS = sbbf_pkg::DEFAULT_MAX_BLOCKS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire sbbf_pkg::item_t             item,
  output logic                             busy,
  input  wire logic                        cfg_wr_en,
  input  wire logic [sbbf_pkg::CFG_W-1:0]  cfg_wr_data,
  output logic                             done,
  output sbbf_pkg::result_t                result
);

  // Handoff between the front end and the queue.
  logic             push;
  sbbf_pkg::entry_t front_entry;

  // Handoff between the queue and the back end.
  logic             pop;
  logic             q_full;
  logic             q_empty;
  sbbf_pkg::entry_t head;

  // The back end reports a clearing sweep so that new items are held off.
  logic             sweeping;

  sbbf_front #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .item        (item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sweeping    (sweeping),
    .q_full      (q_full),
    .busy        (busy),
    .push        (push),
    .entry       (front_entry)
  );

  sbbf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_entry),
    .pop   (pop),
    .rdata (head),
    .full  (q_full),
    .empty (q_empty)
  );

  // The back end owns the block store and issues exactly one result per item.
  sbbf_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .sweeping (sweeping),
    .done     (done),
    .result   (result)
  );

endmodule

`default_nettype wire
